FILE: rtl/smpq_pkg.sv
// Shared types and codes for the stable min-priority queue.
package smpq_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int COST_BITS_DEF = 16;
  localparam int PARENT_BITS   = 24;
  localparam int OPER_BITS     = 16;

  // Action codes carried on the input channel
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Status codes returned on the result channel
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Data carried by one entry besides its cost
  typedef struct packed {
    logic [PARENT_BITS-1:0] parent;
    logic [OPER_BITS-1:0]   oper;
  } payload_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } cell_ctrl_t;

endpackage

FILE: rtl/stable_min_priority_queue_top.sv
// Top level of the stable min-priority queue built as a sorted shift chain.
//
//   channel  direction  handshake          fields
//   in_      input      in_valid/in_ready  action, cost, parent_state, operator_index
//   out_     output     out_valid/out_ready status, popped_parent_state,
//                                          popped_operator, occupancy
//
// One beat is taken per cycle while in_ready is high; its result is registered in
// the output register. Every cell compares its cost with the broadcast key in
// parallel, so push, pop and clear each complete as the beat is accepted.
// The input is ready whenever the output register is empty or being drained.
// Reset empties the chain at once through the per-cell valid bits.
module stable_min_priority_queue_top #(
  parameter int CAPACITY  = smpq_pkg::CAPACITY_DEF,
  parameter int COST_BITS = smpq_pkg::COST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [15:0]                    in_cost,
  input  logic [23:0]                    in_parent_state,
  input  logic [15:0]                    in_operator_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [23:0]                    out_popped_parent_state,
  output logic [15:0]                    out_popped_operator,
  output logic [$clog2(CAPACITY+1)-1:0]  out_occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                  accept;
  logic                  full, empty;
  logic [CW-1:0]         count_r, count_nxt;
  logic [COST_BITS-1:0]  key;
  smpq_pkg::payload_t    new_pay;
  smpq_pkg::cell_ctrl_t  ctrl;
  smpq_pkg::status_t     status_nxt;

  logic [CAPACITY-1:0]   valid_v;
  logic [CAPACITY-1:0]   greater_v;
  logic [COST_BITS-1:0]  cost_a [CAPACITY];
  smpq_pkg::payload_t    pay_a  [CAPACITY];

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  smpq_pkg::payload_t    out_pay_r, out_pay_nxt;
  logic [CW-1:0]         out_occ_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign key      = COST_BITS'(in_cost);
  assign new_pay  = '{parent: in_parent_state, oper: in_operator_index};

  // Decode the action into the chain command and the step status
  always_comb begin
    ctrl       = '0;
    status_nxt = smpq_pkg::ST_DONE;
    count_nxt  = count_r;
    case (in_action)
      smpq_pkg::ACT_PUSH: begin
        if (full) begin
          status_nxt = smpq_pkg::ST_FULL;
        end else begin
          ctrl.push = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      smpq_pkg::ACT_POP: begin
        if (empty) begin
          status_nxt = smpq_pkg::ST_EMPTY;
        end else begin
          ctrl.pop  = accept;
          count_nxt = count_r - CW'(1);
        end
      end
      smpq_pkg::ACT_CLEAR: begin
        ctrl.clr  = accept;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Build the chain, head cell at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 p_valid, p_greater, n_valid;
    logic [COST_BITS-1:0] p_cost, n_cost;
    smpq_pkg::payload_t   p_pay, n_pay;

    if (i == 0) begin : g_head
      assign p_valid   = 1'b1;
      assign p_greater = 1'b0;
      assign p_cost    = '0;
      assign p_pay     = '0;
    end else begin : g_body
      assign p_valid   = valid_v[i-1];
      assign p_greater = greater_v[i-1];
      assign p_cost    = cost_a[i-1];
      assign p_pay     = pay_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_cost  = '0;
      assign n_pay   = '0;
    end else begin : g_link
      assign n_valid = valid_v[i+1];
      assign n_cost  = cost_a[i+1];
      assign n_pay   = pay_a[i+1];
    end

    smpq_cell #(
      .COST_BITS(COST_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .key          (key),
      .new_pay      (new_pay),
      .prev_valid   (p_valid),
      .prev_greater (p_greater),
      .prev_cost    (p_cost),
      .prev_pay     (p_pay),
      .next_valid   (n_valid),
      .next_cost    (n_cost),
      .next_pay     (n_pay),
      .valid        (valid_v[i]),
      .greater      (greater_v[i]),
      .cost         (cost_a[i]),
      .pay          (pay_a[i])
    );
  end

  // Take the head entry on a pop, zero otherwise
  assign out_pay_nxt = ctrl.pop ? pay_a[0] : '0;

  // Hold the count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_status_r <= status_nxt;
      out_pay_r    <= out_pay_nxt;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_popped_parent_state = out_pay_r.parent;
  assign out_popped_operator     = out_pay_r.oper;
  assign out_occupancy           = out_occ_r;

  // Count tracks the number of live cells
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) == $countones(valid_v))
    else $error("entry count differs from live cells");

  // Live cells form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v + CAPACITY'(1)) & valid_v) == '0)
    else $error("gap in the cell chain");

  // Head pair stays in cost order
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    valid_v[1] |-> (cost_a[0] <= cost_a[1]))
    else $error("head cells out of order");

  // A pop on an empty chain reports empty with zero payload
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == smpq_pkg::ACT_POP && empty)
      |=> (out_status_r == smpq_pkg::ST_EMPTY && out_pay_r == '0))
    else $error("empty pop misreported");

endmodule

FILE: rtl/smpq_cell.sv
// One cell of the sorted shift chain: holds one entry and its valid bit.
module smpq_cell #(
  parameter int COST_BITS = smpq_pkg::COST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smpq_pkg::cell_ctrl_t  ctrl,
  input  logic [COST_BITS-1:0]  key,
  input  smpq_pkg::payload_t    new_pay,
  input  logic                  prev_valid,
  input  logic                  prev_greater,
  input  logic [COST_BITS-1:0]  prev_cost,
  input  smpq_pkg::payload_t    prev_pay,
  input  logic                  next_valid,
  input  logic [COST_BITS-1:0]  next_cost,
  input  smpq_pkg::payload_t    next_pay,
  output logic                  valid,
  output logic                  greater,
  output logic [COST_BITS-1:0]  cost,
  output smpq_pkg::payload_t    pay
);

  logic                 valid_r, valid_nxt;
  logic [COST_BITS-1:0] cost_r, cost_nxt;
  smpq_pkg::payload_t   pay_r, pay_nxt;

  // Flag a held entry that sorts after the pushed key
  assign greater = valid_r && (cost_r > key);

  // Shift right from the insertion point on push, left on pop, drop all on clear
  always_comb begin
    valid_nxt = valid_r;
    cost_nxt  = cost_r;
    pay_nxt   = pay_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.pop) begin
      valid_nxt = next_valid;
      cost_nxt  = next_cost;
      pay_nxt   = next_pay;
    end else if (ctrl.push) begin
      if (prev_greater) begin
        valid_nxt = 1'b1;
        cost_nxt  = prev_cost;
        pay_nxt   = prev_pay;
      end else if ((greater || !valid_r) && prev_valid) begin
        valid_nxt = 1'b1;
        cost_nxt  = key;
        pay_nxt   = new_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cost_r <= cost_nxt;
    pay_r  <= pay_nxt;
  end

  assign valid = valid_r;
  assign cost  = cost_r;
  assign pay   = pay_r;

endmodule
